>>> rtl/core/biquad_iir_filter_defines.svh
// ---------------------------------------------------------------------------
// Biquad IIR filter assertion macros
// Property wrappers for the checker file of the filter.
// ---------------------------------------------------------------------------
`ifndef BIQUAD_IIR_FILTER_DEFINES_SVH
`define BIQUAD_IIR_FILTER_DEFINES_SVH

// General property, sampled on clk and ignored while rst_n is low.
`define BIQUAD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A word offered on a stalled channel stays put until it is taken.
`define BIQUAD_ASSERT_HOLD(name, vld, rdy, data, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) \
    (vld && !rdy) |=> (vld && $stable(data))) else $error(msg);

`endif

>>> rtl/core/biquad_pkg.sv
// ---------------------------------------------------------------------------
// Biquad filter package
// Number formats, register map and shared types of the biquad filter.
// ---------------------------------------------------------------------------
package biquad_pkg;

  localparam int CHANNELS    = 2;
  localparam int SAMPLE_BITS = 24;
  localparam int COEF_BITS   = 18;
  localparam int STATE_BITS  = 32;
  localparam int PROD_BITS   = COEF_BITS + STATE_BITS;
  localparam int ACC_BITS    = PROD_BITS + 2;
  localparam int IN_SHIFT    = 41 - SAMPLE_BITS;
  localparam int V_SHIFT     = 16;
  localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int APB_DATA_BITS = 32;
  localparam int REG_IDX_BITS  = 3;
  localparam int APB_ADDR_BITS = REG_IDX_BITS + 2;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4
  } reg_idx_t;

  localparam logic signed [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(65536);

  typedef struct packed {
    logic signed [COEF_BITS-1:0] b0;
    logic signed [COEF_BITS-1:0] b1;
    logic signed [COEF_BITS-1:0] b2;
    logic signed [COEF_BITS-1:0] a1;
    logic signed [COEF_BITS-1:0] a2;
  } coef_set_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  typedef struct packed {
    logic    mul_en;
    acc_op_t acc_op;
  } mac_ctrl_t;

endpackage

>>> rtl/core/biquad_iir_filter.sv
// ---------------------------------------------------------------------------
// Biquad IIR filter
// Direct form II second-order section with separate delay state per channel.
// ---------------------------------------------------------------------------
// Each accepted word (a 24-bit sample and its channel) is filtered with
// v = x - a1*v1 - a2*v2 and y = b0*v + b1*v1 + b2*v2 on one shared 18x32
// multiplier, one product per cycle, under a small sequencer, so in_ready
// stays low from the acceptance of a word until its result is posted, and
// no word is taken meanwhile; the result word sits in an output register
// and the next sample is taken while it waits, unless a second result is
// finished before the first is taken. Coefficients are Q2.16 values at byte
// addresses 0 (b0), 4 (b1), 8 (b2), 12 (a1) and 16 (a2); write them only
// while the block is idle.
// The delay state is Q8.24 and saturates, the output saturates to 24 bits.
module biquad_iir_filter
  import biquad_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [SAMPLE_BITS-1:0]   in_sample_in,
  input  logic                     in_channel,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [SAMPLE_BITS-1:0]   out_sample_out,
  output logic                     out_channel_out,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  coef_set_t                    coef;
  mac_ctrl_t                    mac_ctrl;
  logic signed [COEF_BITS-1:0]  mac_coef;
  logic signed [STATE_BITS-1:0] mac_opnd;
  logic signed [ACC_BITS-1:0]   mac_load;
  logic signed [ACC_BITS-1:0]   mac_acc;

  biquad_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coef    (coef)
  );

  biquad_mac u_mac (
    .clk      (clk),
    .ctrl     (mac_ctrl),
    .coef     (mac_coef),
    .opnd     (mac_opnd),
    .load_val (mac_load),
    .acc      (mac_acc)
  );

  biquad_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample_in    (in_sample_in),
    .in_channel      (in_channel),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sample_out  (out_sample_out),
    .out_channel_out (out_channel_out),
    .coef            (coef),
    .mac_ctrl        (mac_ctrl),
    .mac_coef        (mac_coef),
    .mac_opnd        (mac_opnd),
    .mac_load        (mac_load),
    .mac_acc         (mac_acc)
  );

endmodule

>>> rtl/core/biquad_regs.sv
// ---------------------------------------------------------------------------
// Biquad coefficient registers
// APB-style register file holding the five normalized Q2.16 coefficients.
// ---------------------------------------------------------------------------
module biquad_regs
  import biquad_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready,
  output coef_set_t                coef
);

  coef_set_t coef_r;
  reg_idx_t  idx;
  logic      wr_en;

  assign idx    = reg_idx_t'(paddr[APB_ADDR_BITS-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign coef   = coef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.b0 <= COEF_ONE;
      coef_r.b1 <= '0;
      coef_r.b2 <= '0;
      coef_r.a1 <= '0;
      coef_r.a2 <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_B0:  coef_r.b0 <= pwdata[COEF_BITS-1:0];
        REG_B1:  coef_r.b1 <= pwdata[COEF_BITS-1:0];
        REG_B2:  coef_r.b2 <= pwdata[COEF_BITS-1:0];
        REG_A1:  coef_r.a1 <= pwdata[COEF_BITS-1:0];
        REG_A2:  coef_r.a2 <= pwdata[COEF_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_B0:  prdata = APB_DATA_BITS'(coef_r.b0);
      REG_B1:  prdata = APB_DATA_BITS'(coef_r.b1);
      REG_B2:  prdata = APB_DATA_BITS'(coef_r.b2);
      REG_A1:  prdata = APB_DATA_BITS'(coef_r.a1);
      REG_A2:  prdata = APB_DATA_BITS'(coef_r.a2);
      default: prdata = '0;
    endcase
  end

endmodule

>>> rtl/core/biquad_mac.sv
// ---------------------------------------------------------------------------
// Biquad multiply-accumulate unit
// One registered 18x32 multiplier feeding a wide accumulator.
// ---------------------------------------------------------------------------
module biquad_mac
  import biquad_pkg::*;
(
  input  logic                         clk,
  input  mac_ctrl_t                    ctrl,
  input  logic signed [COEF_BITS-1:0]  coef,
  input  logic signed [STATE_BITS-1:0] opnd,
  input  logic signed [ACC_BITS-1:0]   load_val,
  output logic signed [ACC_BITS-1:0]   acc
);

  logic signed [PROD_BITS-1:0] prod_nxt;
  logic signed [PROD_BITS-1:0] prod_r;
  logic signed [ACC_BITS-1:0]  prod_ext;
  logic signed [ACC_BITS-1:0]  acc_r;

  assign prod_nxt = coef * opnd;
  assign prod_ext = ACC_BITS'(prod_r);
  assign acc      = acc_r;

  // The product lands in prod_r in the cycle before the accumulator uses it.
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= prod_nxt;
    end
    unique case (ctrl.acc_op)
      ACC_HOLD: acc_r <= acc_r;
      ACC_LOAD: acc_r <= load_val;
      ACC_ADD:  acc_r <= acc_r + prod_ext;
      ACC_SUB:  acc_r <= acc_r - prod_ext;
      default:  acc_r <= acc_r;
    endcase
  end

endmodule

>>> rtl/core/biquad_ctrl.sv
// ---------------------------------------------------------------------------
// Biquad sequencer
// Steps the shared MAC through the feedback and feedforward sums, rounds,
// keeps the per-channel delay pairs and holds the output word.
// ---------------------------------------------------------------------------
module biquad_ctrl
  import biquad_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [SAMPLE_BITS-1:0]       in_sample_in,
  input  logic                         in_channel,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [SAMPLE_BITS-1:0]       out_sample_out,
  output logic                         out_channel_out,
  input  coef_set_t                    coef,
  output mac_ctrl_t                    mac_ctrl,
  output logic signed [COEF_BITS-1:0]  mac_coef,
  output logic signed [STATE_BITS-1:0] mac_opnd,
  output logic signed [ACC_BITS-1:0]   mac_load,
  input  logic signed [ACC_BITS-1:0]   mac_acc
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_FB1,
    S_FB2,
    S_FB_END,
    S_RND_V,
    S_FF0,
    S_FF1,
    S_FF2,
    S_FF_END,
    S_DONE
  } state_t;

  localparam int VQ_BITS = ACC_BITS + 1 - V_SHIFT;
  localparam int YQ_BITS = ACC_BITS + 1 - IN_SHIFT;
  localparam logic signed [ACC_BITS:0] V_HALF = (ACC_BITS + 1)'(1) <<< (V_SHIFT - 1);
  localparam logic signed [ACC_BITS:0] Y_HALF = (ACC_BITS + 1)'(1) <<< (IN_SHIFT - 1);

  // Round half up to Q8.24 and clamp to the 32-bit state range.
  function automatic logic [STATE_BITS-1:0] round_v(input logic signed [ACC_BITS-1:0] a);
    logic signed [ACC_BITS:0] s;
    logic [VQ_BITS-1:0]       q;
    logic [VQ_BITS-STATE_BITS:0] top;
    s   = {a[ACC_BITS-1], a} + V_HALF;
    q   = s[ACC_BITS:V_SHIFT];
    top = q[VQ_BITS-1:STATE_BITS-1];
    if ((&top) || !(|top)) begin
      round_v = q[STATE_BITS-1:0];
    end else if (q[VQ_BITS-1]) begin
      round_v = {1'b1, {(STATE_BITS-1){1'b0}}};
    end else begin
      round_v = {1'b0, {(STATE_BITS-1){1'b1}}};
    end
  endfunction

  // Round half up to the sample format and clamp to full scale.
  function automatic logic [SAMPLE_BITS-1:0] round_y(input logic signed [ACC_BITS-1:0] a);
    logic signed [ACC_BITS:0] s;
    logic [YQ_BITS-1:0]       q;
    logic [YQ_BITS-SAMPLE_BITS:0] top;
    s   = {a[ACC_BITS-1], a} + Y_HALF;
    q   = s[ACC_BITS:IN_SHIFT];
    top = q[YQ_BITS-1:SAMPLE_BITS-1];
    if ((&top) || !(|top)) begin
      round_y = q[SAMPLE_BITS-1:0];
    end else if (q[YQ_BITS-1]) begin
      round_y = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      round_y = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  endfunction

  state_t                        state_r, state_nxt;
  logic [SAMPLE_BITS-1:0]        x_r;
  logic                          ch_r;
  logic signed [STATE_BITS-1:0]  v_r;
  logic signed [STATE_BITS-1:0]  delay_one_r [CHANNELS];
  logic signed [STATE_BITS-1:0]  delay_two_r [CHANNELS];
  logic                          out_valid_r;
  logic [SAMPLE_BITS-1:0]        out_sample_r;
  logic                          out_channel_r;
  logic [CH_W-1:0]               idx;
  logic signed [STATE_BITS-1:0]  v1, v2;
  logic                          retire;

  assign idx       = CH_W'(ch_r % CHANNELS);
  assign v1        = delay_one_r[idx];
  assign v2        = delay_two_r[idx];
  assign in_ready  = (state_r == S_IDLE);
  assign retire    = (state_r == S_DONE) && (!out_valid_r || out_ready);

  assign out_valid       = out_valid_r;
  assign out_sample_out  = out_sample_r;
  assign out_channel_out = out_channel_r;

  // The first accumulator load is the sample moved up to 40 fraction bits.
  assign mac_load = (state_r == S_FB1)
                  ? {{(ACC_BITS-SAMPLE_BITS-IN_SHIFT){x_r[SAMPLE_BITS-1]}},
                     x_r, {IN_SHIFT{1'b0}}}
                  : '0;

  always_comb begin
    state_nxt       = state_r;
    mac_ctrl.mul_en = 1'b0;
    mac_ctrl.acc_op = ACC_HOLD;
    mac_coef        = coef.a1;
    mac_opnd        = v1;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_FB1;
      end
      S_FB1: begin
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.acc_op = ACC_LOAD;
        state_nxt       = S_FB2;
      end
      S_FB2: begin
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.acc_op = ACC_SUB;
        mac_coef        = coef.a2;
        mac_opnd        = v2;
        state_nxt       = S_FB_END;
      end
      S_FB_END: begin
        mac_ctrl.acc_op = ACC_SUB;
        state_nxt       = S_RND_V;
      end
      S_RND_V: begin
        state_nxt = S_FF0;
      end
      S_FF0: begin
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.acc_op = ACC_LOAD;
        mac_coef        = coef.b0;
        mac_opnd        = v_r;
        state_nxt       = S_FF1;
      end
      S_FF1: begin
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.acc_op = ACC_ADD;
        mac_coef        = coef.b1;
        state_nxt       = S_FF2;
      end
      S_FF2: begin
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.acc_op = ACC_ADD;
        mac_coef        = coef.b2;
        mac_opnd        = v2;
        state_nxt       = S_FF_END;
      end
      S_FF_END: begin
        mac_ctrl.acc_op = ACC_ADD;
        state_nxt       = S_DONE;
      end
      S_DONE: begin
        if (retire) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      out_sample_r  <= '0;
      out_channel_r <= 1'b0;
      x_r           <= '0;
      ch_r          <= 1'b0;
      v_r           <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        delay_one_r[i] <= '0;
        delay_two_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (in_valid && in_ready) begin
        x_r  <= in_sample_in;
        ch_r <= in_channel;
      end
      if (state_r == S_RND_V) begin
        v_r <= round_v(mac_acc);
      end
      // The delay pair shifts in the same cycle the result word is posted.
      if (retire) begin
        out_valid_r       <= 1'b1;
        out_sample_r      <= round_y(mac_acc);
        out_channel_r     <= ch_r;
        delay_two_r[idx]  <= v1;
        delay_one_r[idx]  <= v_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/core/biquad_checker.sv
// ---------------------------------------------------------------------------
// Biquad filter checker
// Port-level assertions on the filter's word channels, bound to the top.
// ---------------------------------------------------------------------------
`include "biquad_iir_filter_defines.svh"

module biquad_checker
  import biquad_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] out_sample_out,
  input logic                   out_channel_out
);

  // Once a sample is taken, the block must show itself busy with in_ready low.
  `BIQUAD_ASSERT(a_busy, (in_valid && in_ready) |=> !in_ready [*3], "word taken while busy")

  // The block only returns to idle after posting a result word.
  `BIQUAD_ASSERT(a_idle_with_result, $rose(in_ready) |-> out_valid, "idle without a result word")

  `BIQUAD_ASSERT_HOLD(a_sample_hold, out_valid, out_ready, out_sample_out, "sample changed")

  `BIQUAD_ASSERT_HOLD(a_channel_hold, out_valid, out_ready, out_channel_out, "channel changed")

endmodule

bind biquad_iir_filter biquad_checker u_biquad_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_sample_out  (out_sample_out),
  .out_channel_out (out_channel_out)
);
